FILE: hw/rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types and constants of the particle pool: command codes, register
// indexes, slot record layout and the words that pass between the modules.
// ----------------------------------------------------------------------------
package ppg_pkg;

	localparam int PARTICLE_SLOTS = 32;
	localparam int SLOT_W = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
	localparam int SLOT_OUT_W = 6;
	localparam int BURST_COUNT = 8;
	localparam int BURST_W = $clog2(BURST_COUNT);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		CMD_SPAWN = 2'd0,
		CMD_BURST = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BURST_SPEED  = 2'd0,
		REG_BURST_LIFE   = 2'd1,
		REG_GRAVITY_STEP = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPAWN,
		ST_BURST,
		ST_TK_RD,
		ST_TK_WB,
		ST_TK_EMPTY
	} seq_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [7:0]  color;
		logic [7:0]  life;
	} cmd_word_t;

	typedef struct packed {
		logic                  result_kind;
		logic                  has_particle;
		logic                  accepted;
		logic [SLOT_OUT_W-1:0] slot;
		logic [15:0]           out_x;
		logic [15:0]           out_y;
		logic [7:0]            out_color;
		logic                  still_alive;
		logic                  last;
	} res_word_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] vx;
		logic [15:0] vy;
		logic [7:0]  color;
		logic [7:0]  life;
	} slot_rec_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		slot_rec_t         data;
	} ram_wr_t;

	typedef struct packed {
		logic              set_en;
		logic [SLOT_W-1:0] set_idx;
		logic              clr_en;
		logic [SLOT_W-1:0] clr_idx;
		logic [SLOT_W-1:0] query_idx;
	} pool_req_t;

	typedef struct packed {
		logic              free_found;
		logic [SLOT_W-1:0] free_idx;
		logic              q_active;
		logic              q_later;
		logic              any_active;
	} pool_sts_t;

endpackage

FILE: hw/rtl/ppg_ifs.sv
// ----------------------------------------------------------------------------
// ppg channel interfaces
// Command, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppg_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic [7:0]         color;
	logic [7:0]         life;

	modport source (output valid, command, pos_x, pos_y, vel_x, vel_y, color, life,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, vel_x, vel_y, color, life,
		output ready);
endinterface

interface ppg_res_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic               has_particle;
	logic               accepted;
	logic [5:0]         slot;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [7:0]         out_color;
	logic               still_alive;
	logic               last;

	modport source (output valid, result_kind, has_particle, accepted, slot, out_x,
		out_y, out_color, still_alive, last, input ready);
	modport sink (input valid, result_kind, has_particle, accepted, slot, out_x,
		out_y, out_color, still_alive, last, output ready);
endinterface

interface ppg_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/particle_pool_with_gravity_top.sv
// ----------------------------------------------------------------------------
// particle_pool_with_gravity_top
// Fixed pool of particle slots with spawn, eight-way burst and gravity tick.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - command words in: spawn one particle, spawn an eight-way burst,
//          or tick. One word is taken at a time; cmd.ready is high only
//          while the sequencer is idle. Command code 3 is taken and dropped.
//   res  - result words out, one output register deep. The final word of
//          each command carries last.
//   cfg  - register writes (burst speed, burst life, gravity step), always
//          ready; write only while no command is in progress.
// Operation:
//   spawn  one slot allocation, one result.
//   burst  eight slot allocations and eight results, one of each per cycle
//          while the output register is free.
//   tick   sweeps the slot store: a free slot is skipped, an active slot is
//          read, then updated and written back, stopping after the highest
//          active slot; an empty pool gives one result.
// Reset: all slots free, registers at 2 / 15 / 1; slot contents are not
//   cleared, no clearing pass is needed.
// Stall: while res.ready is low the sequencer holds with the word in the
//   output register; nothing is lost and work resumes when it is taken.
// ----------------------------------------------------------------------------
module particle_pool_with_gravity_top (
	input  logic      clk,
	input  logic      arst_n,
	ppg_cmd_if.sink   cmd,
	ppg_res_if.source res,
	ppg_cfg_if.sink   cfg
);

	// configuration registers
	logic [6:0] burst_speed_q;
	logic [7:0] burst_life_q;
	logic [3:0] gravity_step_q;

	ppg_pkg::cmd_word_t  cmd_word;
	ppg_pkg::res_word_t  res_word;
	ppg_pkg::pool_req_t  pool_req;
	ppg_pkg::pool_sts_t  pool_sts;
	ppg_pkg::ram_wr_t    ram_wr;
	ppg_pkg::slot_rec_t  ram_rdata;
	logic                ram_re;
	logic [ppg_pkg::SLOT_W-1:0] ram_raddr;

	assign cfg.ready = 1'b1;

	// writes beyond the register list fall through the default arm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_speed_q  <= 7'd2;
			burst_life_q   <= 8'd15;
			gravity_step_q <= 4'd1;
		end else if (cfg.valid) begin
			case (ppg_pkg::reg_idx_t'(cfg.index))
				ppg_pkg::REG_BURST_SPEED:  burst_speed_q  <= cfg.data[6:0];
				ppg_pkg::REG_BURST_LIFE:   burst_life_q   <= cfg.data;
				ppg_pkg::REG_GRAVITY_STEP: gravity_step_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// command word
	assign cmd_word.command = cmd.command;
	assign cmd_word.pos_x   = cmd.pos_x;
	assign cmd_word.pos_y   = cmd.pos_y;
	assign cmd_word.vel_x   = cmd.vel_x;
	assign cmd_word.vel_y   = cmd.vel_y;
	assign cmd_word.color   = cmd.color;
	assign cmd_word.life    = cmd.life;

	// result word
	assign res.result_kind  = res_word.result_kind;
	assign res.has_particle = res_word.has_particle;
	assign res.accepted     = res_word.accepted;
	assign res.slot         = res_word.slot;
	assign res.out_x        = res_word.out_x;
	assign res.out_y        = res_word.out_y;
	assign res.out_color    = res_word.out_color;
	assign res.still_alive  = res_word.still_alive;
	assign res.last         = res_word.last;

	// spawn and tick never overlap, so reads and writes of one slot
	// cannot collide in the store
	ppg_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd.valid),
		.cmd_ready    (cmd.ready),
		.cmd_word     (cmd_word),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.res_word     (res_word),
		.burst_speed  (burst_speed_q),
		.burst_life   (burst_life_q),
		.gravity_step (gravity_step_q),
		.pool_req     (pool_req),
		.pool_sts     (pool_sts),
		.ram_wr       (ram_wr),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	ppg_pool_map u_pool_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pool_req),
		.sts    (pool_sts)
	);

	ppg_slot_ram u_slot_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: hw/rtl/ppg_slot_ram.sv
// ----------------------------------------------------------------------------
// ppg_slot_ram
// Slot record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppg_slot_ram (
	input  logic                          clk,
	input  ppg_pkg::ram_wr_t              wr,
	input  logic                          re,
	input  logic [ppg_pkg::SLOT_W-1:0]    raddr,
	output ppg_pkg::slot_rec_t            rdata
);

	ppg_pkg::slot_rec_t mem [ppg_pkg::PARTICLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/ppg_pool_map.sv
// ----------------------------------------------------------------------------
// ppg_pool_map
// Active marks of all slots: lowest free slot, per-slot query and a look
// ahead for any active slot above the queried one.
// ----------------------------------------------------------------------------
module ppg_pool_map (
	input  logic                clk,
	input  logic                arst_n,
	input  ppg_pkg::pool_req_t  req,
	output ppg_pkg::pool_sts_t  sts
);

	logic [ppg_pkg::PARTICLE_SLOTS-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (req.set_en) begin
				active_q[req.set_idx] <= 1'b1;
			end
			if (req.clr_en) begin
				active_q[req.clr_idx] <= 1'b0;
			end
		end
	end

	// lowest free slot: scan from the top so the lowest one wins
	always_comb begin
		sts.free_found = 1'b0;
		sts.free_idx   = '0;
		for (int j = ppg_pkg::PARTICLE_SLOTS - 1; j >= 0; j--) begin
			if (!active_q[j]) begin
				sts.free_found = 1'b1;
				sts.free_idx   = ppg_pkg::SLOT_W'(j);
			end
		end
	end

	always_comb begin
		sts.q_later = 1'b0;
		for (int j = 0; j < ppg_pkg::PARTICLE_SLOTS; j++) begin
			if (active_q[j] && (ppg_pkg::SLOT_W'(j) > req.query_idx)) begin
				sts.q_later = 1'b1;
			end
		end
	end

	assign sts.q_active   = active_q[req.query_idx];
	assign sts.any_active = |active_q;

endmodule

FILE: hw/rtl/ppg_seq.sv
// ----------------------------------------------------------------------------
// ppg_seq
// Command sequencer: spawn, eight-way burst and the read-modify-write sweep
// of a tick, with the result output register.
// ----------------------------------------------------------------------------
module ppg_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  ppg_pkg::cmd_word_t            cmd_word,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ppg_pkg::res_word_t            res_word,
	input  logic [6:0]                    burst_speed,
	input  logic [7:0]                    burst_life,
	input  logic [3:0]                    gravity_step,
	output ppg_pkg::pool_req_t            pool_req,
	input  ppg_pkg::pool_sts_t            pool_sts,
	output ppg_pkg::ram_wr_t              ram_wr,
	output logic                          ram_re,
	output logic [ppg_pkg::SLOT_W-1:0]    ram_raddr,
	input  ppg_pkg::slot_rec_t            ram_rdata
);

	ppg_pkg::seq_state_t state_q, state_d;
	ppg_pkg::cmd_word_t  cmd_q;
	ppg_pkg::res_word_t  res_q, res_next;
	logic                res_valid_q;
	logic                res_load;
	logic                ob_free;
	logic [ppg_pkg::SLOT_W-1:0]  idx_q;
	logic [ppg_pkg::BURST_W-1:0] dir_q;
	logic                idx_inc, idx_clr, dir_inc, dir_clr, cmd_load;
	logic                burst_end;
	logic [15:0]         spd, spd_neg;
	logic [15:0]         bvx, bvy;
	logic [15:0]         tk_x, tk_y, tk_vy;
	logic                tk_alive;

	// zero life behaves as one
	function automatic logic [7:0] life_fix(input logic [7:0] l);
		return (l == 8'd0) ? 8'd1 : l;
	endfunction

	assign ob_free   = !res_valid_q || res_ready;
	assign burst_end = (dir_q == ppg_pkg::BURST_W'(ppg_pkg::BURST_COUNT - 1));

	// burst velocity: directions (-1,-1) (0,-1) (1,-1) (-1,0) (1,0) (-1,1) (0,1) (1,1)
	assign spd     = 16'(burst_speed);
	assign spd_neg = 16'd0 - spd;

	always_comb begin
		case (dir_q)
			3'd0, 3'd3, 3'd5: bvx = spd_neg;
			3'd2, 3'd4, 3'd7: bvx = spd;
			default:          bvx = 16'd0;
		endcase
		case (dir_q)
			3'd0, 3'd1, 3'd2: bvy = spd_neg;
			3'd5, 3'd6, 3'd7: bvy = spd;
			default:          bvy = 16'd0;
		endcase
	end

	// tick update of the record just read
	assign tk_x     = ram_rdata.x + ram_rdata.vx;
	assign tk_y     = ram_rdata.y + ram_rdata.vy;
	assign tk_vy    = ram_rdata.vy + 16'(gravity_step);
	assign tk_alive = (ram_rdata.life > 8'd1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ppg_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (ppg_pkg::cmd_t'(cmd_word.command))
						ppg_pkg::CMD_SPAWN: state_d = ppg_pkg::ST_SPAWN;
						ppg_pkg::CMD_BURST: state_d = ppg_pkg::ST_BURST;
						ppg_pkg::CMD_TICK: state_d = pool_sts.any_active ?
							ppg_pkg::ST_TK_RD : ppg_pkg::ST_TK_EMPTY;
						default: state_d = ppg_pkg::ST_IDLE;
					endcase
				end
			end
			ppg_pkg::ST_SPAWN: begin
				if (ob_free) state_d = ppg_pkg::ST_IDLE;
			end
			ppg_pkg::ST_BURST: begin
				if (ob_free && burst_end) state_d = ppg_pkg::ST_IDLE;
			end
			ppg_pkg::ST_TK_RD: begin
				if (pool_sts.q_active) state_d = ppg_pkg::ST_TK_WB;
			end
			ppg_pkg::ST_TK_WB: begin
				if (ob_free) begin
					state_d = pool_sts.q_later ? ppg_pkg::ST_TK_RD : ppg_pkg::ST_IDLE;
				end
			end
			ppg_pkg::ST_TK_EMPTY: begin
				if (ob_free) state_d = ppg_pkg::ST_IDLE;
			end
			default: state_d = ppg_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready          = 1'b0;
		cmd_load           = 1'b0;
		res_load           = 1'b0;
		res_next           = '0;
		pool_req           = '0;
		pool_req.query_idx = idx_q;
		ram_wr             = '0;
		ram_re             = 1'b0;
		ram_raddr          = idx_q;
		idx_inc            = 1'b0;
		idx_clr            = 1'b0;
		dir_inc            = 1'b0;
		dir_clr            = 1'b0;
		case (state_q)
			ppg_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				cmd_load  = cmd_valid;
				idx_clr   = 1'b1;
				dir_clr   = 1'b1;
			end
			ppg_pkg::ST_SPAWN, ppg_pkg::ST_BURST: begin
				if (ob_free) begin
					res_load              = 1'b1;
					res_next.has_particle = pool_sts.free_found;
					res_next.accepted     = pool_sts.free_found;
					res_next.still_alive  = pool_sts.free_found;
					res_next.slot         = pool_sts.free_found ?
						ppg_pkg::SLOT_OUT_W'(pool_sts.free_idx) : '0;
					res_next.out_x        = cmd_q.pos_x;
					res_next.out_y        = cmd_q.pos_y;
					res_next.out_color    = cmd_q.color;
					res_next.last         = (state_q == ppg_pkg::ST_SPAWN) || burst_end;
					ram_wr.en             = pool_sts.free_found;
					ram_wr.addr           = pool_sts.free_idx;
					ram_wr.data.x         = cmd_q.pos_x;
					ram_wr.data.y         = cmd_q.pos_y;
					ram_wr.data.color     = cmd_q.color;
					if (state_q == ppg_pkg::ST_SPAWN) begin
						ram_wr.data.vx   = cmd_q.vel_x;
						ram_wr.data.vy   = cmd_q.vel_y;
						ram_wr.data.life = life_fix(cmd_q.life);
					end else begin
						ram_wr.data.vx   = bvx;
						ram_wr.data.vy   = bvy;
						ram_wr.data.life = life_fix(burst_life);
					end
					pool_req.set_en  = pool_sts.free_found;
					pool_req.set_idx = pool_sts.free_idx;
					dir_inc          = 1'b1;
				end
			end
			ppg_pkg::ST_TK_RD: begin
				if (pool_sts.q_active) begin
					ram_re = 1'b1;
				end else begin
					idx_inc = 1'b1;
				end
			end
			ppg_pkg::ST_TK_WB: begin
				if (ob_free) begin
					ram_wr.en             = 1'b1;
					ram_wr.addr           = idx_q;
					ram_wr.data.x         = tk_x;
					ram_wr.data.y         = tk_y;
					ram_wr.data.vx        = ram_rdata.vx;
					ram_wr.data.vy        = tk_vy;
					ram_wr.data.color     = ram_rdata.color;
					ram_wr.data.life      = tk_alive ? (ram_rdata.life - 8'd1) : 8'd0;
					pool_req.clr_en       = !tk_alive;
					pool_req.clr_idx      = idx_q;
					res_load              = 1'b1;
					res_next.result_kind  = 1'b1;
					res_next.has_particle = 1'b1;
					res_next.slot         = ppg_pkg::SLOT_OUT_W'(idx_q);
					res_next.out_x        = tk_x;
					res_next.out_y        = tk_y;
					res_next.out_color    = ram_rdata.color;
					res_next.still_alive  = tk_alive;
					res_next.last         = !pool_sts.q_later;
					idx_inc               = 1'b1;
				end
			end
			ppg_pkg::ST_TK_EMPTY: begin
				if (ob_free) begin
					res_load             = 1'b1;
					res_next.result_kind = 1'b1;
					res_next.last        = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppg_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
			dir_q       <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (dir_clr) begin
				dir_q <= '0;
			end else if (dir_inc) begin
				dir_q <= dir_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_load) begin
			cmd_q <= cmd_word;
		end
		if (res_load) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

FILE: hw/rtl/ppg_checker.sv
// ----------------------------------------------------------------------------
// ppg_checker
// Port-level checks of the particle pool, bound to the top level.
// ----------------------------------------------------------------------------
module ppg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  cmd_command,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_kind,
	input logic        res_has,
	input logic        res_acc,
	input logic [5:0]  res_slot,
	input logic        res_alive,
	input logic        res_last,
	input logic [15:0] res_x
);

	// a real command keeps the channel closed on the following cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready && (cmd_command != 2'd3)) |=> !cmd_ready)
		else $error("command channel open right after a command");

	// stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_slot) &&
		$stable(res_x) && $stable(res_last)))
		else $error("stalled result word changed");

	// empty tick report is final and carries slot zero
	a_empty_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_kind && !res_has) |-> (res_last && (res_slot == 6'd0) &&
		!res_alive))
		else $error("bad empty tick report");

	// spawn report flags agree; tick reports never claim acceptance
	a_report_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_kind ? !res_acc :
		((res_has == res_acc) && (res_alive == res_acc))))
		else $error("inconsistent report flags");

endmodule

bind particle_pool_with_gravity_top ppg_checker u_ppg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_command (cmd.command),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_kind    (res.result_kind),
	.res_has     (res.has_particle),
	.res_acc     (res.accepted),
	.res_slot    (res.slot),
	.res_alive   (res.still_alive),
	.res_last    (res.last),
	.res_x       (res.out_x)
);

FILE: tb/particle_pool_checker.sv
// ----------------------------------------------------------------------------
// particle_pool_checker
// Watches the command, result and register channels of the particle pool.
// Keeps its own copy of the slot store and the registers, works out the
// result words of each command taken, and compares every word taken from the
// result channel, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module particle_pool_checker (
	input  logic clk,
	input  logic arst_n,
	ppg_cmd_if   cmd,
	ppg_res_if   res,
	ppg_cfg_if   cfg,
	output int   mismatches,
	output int   n_pending,
	output int   n_checked,
	output int   n_refused
);
	import ppg_pkg::*;

	localparam int SHOW_LIMIT = 10;

	logic [6:0]  speed_reg;
	logic [7:0]  life_reg;
	logic [3:0]  gravity_reg;

	logic        live   [PARTICLE_SLOTS];
	logic [15:0] p_x    [PARTICLE_SLOTS];
	logic [15:0] p_y    [PARTICLE_SLOTS];
	logic [15:0] p_vx   [PARTICLE_SLOTS];
	logic [15:0] p_vy   [PARTICLE_SLOTS];
	logic [7:0]  p_col  [PARTICLE_SLOTS];
	logic [8:0]  p_life [PARTICLE_SLOTS];

	res_word_t   due_reports[$];

	function automatic string show(input res_word_t w);
		return $sformatf("kind %0d has %0d acc %0d slot %0d x %0d y %0d colour %0d alive %0d last %0d",
			w.result_kind, w.has_particle, w.accepted, w.slot, $signed(w.out_x),
			$signed(w.out_y), w.out_color, w.still_alive, w.last);
	endfunction

	// lowest free slot wins; -1 when the pool is full
	function automatic int place_particle(input logic [15:0] x, y, vx, vy,
		input logic [7:0] colour, ttl);
		for (int i = 0; i < PARTICLE_SLOTS; i++) begin
			if (!live[i]) begin
				p_x[i]    = x;
				p_y[i]    = y;
				p_vx[i]   = vx;
				p_vy[i]   = vy;
				p_col[i]  = colour;
				p_life[i] = (ttl == 8'd0) ? 9'd1 : {1'b0, ttl};
				live[i]   = 1'b1;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void note_spawn(input int s, input logic [15:0] x, y,
		input logic [7:0] colour, input logic fin);
		res_word_t w;
		w              = '0;
		w.has_particle = (s >= 0);
		w.accepted     = (s >= 0);
		w.slot         = (s >= 0) ? SLOT_OUT_W'(s) : '0;
		w.out_x        = x;
		w.out_y        = y;
		w.out_color    = colour;
		w.still_alive  = (s >= 0);
		w.last         = fin;
		if (s < 0)
			n_refused++;
		due_reports.push_back(w);
	endfunction

	function automatic void predict_burst(input logic [15:0] x, y, input logic [7:0] colour);
		logic [15:0] sp;
		logic [15:0] bvx;
		logic [15:0] bvy;
		int          nb;
		int          dx;
		int          dy;
		sp = {9'd0, speed_reg};
		for (int i = 0; i < BURST_COUNT; i++) begin
			// raster walk of the 3x3 neighbourhood, centre skipped
			nb  = (i < 4) ? i : i + 1;
			dx  = nb % 3 - 1;
			dy  = nb / 3 - 1;
			bvx = (dx < 0) ? 16'd0 - sp : (dx > 0) ? sp : 16'd0;
			bvy = (dy < 0) ? 16'd0 - sp : (dy > 0) ? sp : 16'd0;
			note_spawn(place_particle(x, y, bvx, bvy, colour, life_reg), x, y, colour,
				i == BURST_COUNT - 1);
		end
	endfunction

	function automatic void predict_tick();
		res_word_t w;
		int        top_slot;
		top_slot = -1;
		for (int i = 0; i < PARTICLE_SLOTS; i++)
			if (live[i])
				top_slot = i;
		if (top_slot < 0) begin
			w             = '0;
			w.result_kind = 1'b1;
			w.last        = 1'b1;
			due_reports.push_back(w);
			return;
		end
		for (int i = 0; i < PARTICLE_SLOTS; i++) begin
			if (live[i]) begin
				p_x[i]         = p_x[i] + p_vx[i];
				p_y[i]         = p_y[i] + p_vy[i];
				p_vy[i]        = p_vy[i] + {12'd0, gravity_reg};
				w              = '0;
				w.result_kind  = 1'b1;
				w.has_particle = 1'b1;
				w.slot         = SLOT_OUT_W'(i);
				w.out_x        = p_x[i];
				w.out_y        = p_y[i];
				w.out_color    = p_col[i];
				if (p_life[i] <= 9'd1) begin
					p_life[i]     = 9'd0;
					live[i]       = 1'b0;
					w.still_alive = 1'b0;
				end else begin
					p_life[i]     = p_life[i] - 9'd1;
					w.still_alive = 1'b1;
				end
				w.last = (i == top_slot);
				due_reports.push_back(w);
			end
		end
	endfunction

	function automatic void check_word(input res_word_t got);
		res_word_t want;
		if (due_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("unexpected result word: %s", show(got));
			return;
		end
		want = due_reports.pop_front();
		n_checked++;
		if (got.result_kind !== want.result_kind || got.has_particle !== want.has_particle ||
			got.accepted !== want.accepted || got.slot !== want.slot ||
			got.out_x !== want.out_x || got.out_y !== want.out_y ||
			got.out_color !== want.out_color || got.still_alive !== want.still_alive ||
			got.last !== want.last) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("result word %0d differs\n  expected %s\n  actual   %s",
					n_checked, show(want), show(got));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_word_t got;
		if (!arst_n) begin
			speed_reg   = 7'd2;
			life_reg    = 8'd15;
			gravity_reg = 4'd1;
			for (int i = 0; i < PARTICLE_SLOTS; i++)
				live[i] = 1'b0;
			due_reports.delete();
			mismatches = 0;
			n_pending  = 0;
			n_checked  = 0;
			n_refused  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BURST_SPEED:  speed_reg   = cfg.data[6:0];
					REG_BURST_LIFE:   life_reg    = cfg.data;
					REG_GRAVITY_STEP: gravity_reg = cfg.data[3:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got = {res.result_kind, res.has_particle, res.accepted, res.slot, res.out_x,
					res.out_y, res.out_color, res.still_alive, res.last};
				check_word(got);
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.command)
					CMD_SPAWN: note_spawn(place_particle(cmd.pos_x, cmd.pos_y, cmd.vel_x,
						cmd.vel_y, cmd.color, cmd.life), cmd.pos_x, cmd.pos_y, cmd.color, 1'b1);
					CMD_BURST: predict_burst(cmd.pos_x, cmd.pos_y, cmd.color);
					CMD_TICK:  predict_tick();
					default: ;
				endcase
			end
			n_pending = due_reports.size();
		end
	end

endmodule

FILE: tb/particle_pool_with_gravity_top_tb.sv
// ----------------------------------------------------------------------------
// particle_pool_with_gravity_top_tb
// Drives spawn, burst and tick commands and register writes into the particle
// pool, with random gaps on the command side and random stalls on the result
// side. A checker beside the block predicts and compares every result word;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module particle_pool_with_gravity_top_tb;
	import ppg_pkg::*;

	// command code the block takes and drops, and a register index past the list
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int PHASES          = 4;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int MAX_GAP         = 10;
	// length of a full tick sweep over every slot, with a margin on top
	localparam int SETTLE_CYCLES   = 2 * PARTICLE_SLOTS + 16;
	// bound on the length of the whole run, held by the watchdog
	localparam int CYCLE_LIMIT     = 1000000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int cycles   = 0;
	int n_spawn  = 0;
	int n_burst  = 0;
	int n_tick   = 0;
	int n_unused = 0;
	int n_writes = 0;
	bit src_calm = 1'b0;
	bit snk_calm = 1'b0;

	int mismatches;
	int n_pending;
	int n_checked;
	int n_refused;

	ppg_cmd_if cmd_ch ();
	ppg_res_if res_ch ();
	ppg_cfg_if cfg_ch ();

	particle_pool_with_gravity_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	particle_pool_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.n_pending  (n_pending),
		.n_checked  (n_checked),
		.n_refused  (n_refused)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost result word ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words still due", cycles, n_pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: a random stall before each word, with calm
	// stretches of no stall at all so back-to-back words are seen too.
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				snk_calm = !snk_calm;
			stall = snk_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	function automatic cmd_word_t make_word(input logic [1:0] c,
		input logic [15:0] x, y, vx, vy, input logic [7:0] colour, ttl);
		cmd_word_t w;
		w.command = c;
		w.pos_x   = x;
		w.pos_y   = y;
		w.vel_x   = vx;
		w.vel_y   = vy;
		w.color   = colour;
		w.life    = ttl;
		return w;
	endfunction

	// half slow drifts, half anything in 16 bits so wrap gets hit
	function automatic logic [15:0] random_velocity();
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(0, 160)) - 16'd80;
		return 16'($urandom);
	endfunction

	// Mostly short lives so slots keep freeing up; the odd long one, and some
	// commands with the unused code, which the block must swallow silently.
	function automatic cmd_word_t random_item();
		int         pick;
		logic [1:0] c;
		logic [7:0] ttl;
		pick = $urandom_range(0, 99);
		if (pick < 42)
			c = CMD_SPAWN;
		else if (pick < 56)
			c = CMD_BURST;
		else if (pick < 95)
			c = CMD_TICK;
		else
			c = CMD_UNUSED;
		ttl = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
		return make_word(c, 16'($urandom), 16'($urandom), random_velocity(),
			random_velocity(), 8'($urandom), ttl);
	endfunction

	// One command word. valid stays up across back-to-back words; it only
	// drops when a gap is drawn, so it never gets two assignments in one step.
	task automatic issue(input cmd_word_t w);
		int gap;
		if ($urandom_range(0, 15) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= w.command;
		cmd_ch.pos_x   <= w.pos_x;
		cmd_ch.pos_y   <= w.pos_y;
		cmd_ch.vel_x   <= w.vel_x;
		cmd_ch.vel_y   <= w.vel_y;
		cmd_ch.color   <= w.color;
		cmd_ch.life    <= w.life;
		do @(posedge clk); while (!cmd_ch.ready);
		case (w.command)
			CMD_SPAWN: n_spawn++;
			CMD_BURST: n_burst++;
			CMD_TICK:  n_tick++;
			default:   n_unused++;
		endcase
	endtask

	// valid drops after each write, which keeps it to a single assignment per step
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		n_writes++;
	endtask

	task automatic configure(input logic [7:0] speed, ttl, gravity);
		write_reg(REG_BURST_SPEED, speed);
		write_reg(REG_BURST_LIFE, ttl);
		write_reg(REG_GRAVITY_STEP, gravity);
	endtask

	// Drain: every due word in, then the length of a full tick sweep, since a
	// dropped command code leaves nothing to wait for.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int done;
		cmd_word_t w;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.command <= CMD_SPAWN;
		cmd_ch.pos_x   <= '0;
		cmd_ch.pos_y   <= '0;
		cmd_ch.vel_x   <= '0;
		cmd_ch.vel_y   <= '0;
		cmd_ch.color   <= '0;
		cmd_ch.life    <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= REG_BURST_SPEED;
		cfg_ch.data    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, registers still at their reset values ---
		// tick with nothing alive: single empty report
		issue(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
		// field extremes; life zero must live one tick
		issue(make_word(CMD_SPAWN, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
		issue(make_word(CMD_SPAWN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 8'h00, 8'hFF));
		// eight-way burst at reset speed and life
		issue(make_word(CMD_BURST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hA5, 8'h00));
		// positions wrap, the life-zero particle dies here
		issue(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
		// unused code, all ones: no result
		issue(make_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
		issue(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
		// fill the pool; the last burst runs out of slots part-way
		issue(make_word(CMD_BURST, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 8'h01, 8'h00));
		issue(make_word(CMD_BURST, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 8'h80, 8'h00));
		issue(make_word(CMD_BURST, 16'h1234, 16'hEDCB, 16'h0000, 16'h0000, 8'h5A, 8'h00));
		// pool full: single spawn and a whole burst are refused
		issue(make_word(CMD_SPAWN, 16'h0101, 16'h0202, 16'h0003, 16'h0004, 8'h33, 8'h05));
		issue(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
		issue(make_word(CMD_BURST, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'h00));
		issue(make_word(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
		settle();

		// --- random phases, one register setting each ---
		// top bits of the data byte set where the register is narrower
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(8'hFF, 8'h00, 8'hFF);          // fastest, life 0, heaviest
				1: begin
					configure(8'h80, 8'd3, 8'hF0);          // no speed, no gravity
					write_reg(REG_UNUSED, 8'hFF);           // must change nothing
				end
				2: configure(8'($urandom), 8'($urandom_range(2, 12)), 8'($urandom));
				default: configure(8'($urandom), 8'hFF, 8'($urandom));  // longest life last
			endcase
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				w = random_item();
				issue(w);
				if (w.command != CMD_UNUSED)
					done++;
			end
			settle();
		end

		$display("covered %0d commands: %0d spawn, %0d burst, %0d tick, %0d unused code",
			n_spawn + n_burst + n_tick + n_unused, n_spawn, n_burst, n_tick, n_unused);
		$display("%0d result words checked, %0d placements refused on a full pool, %0d register writes",
			n_checked, n_refused, n_writes);
		if (mismatches == 0 && n_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_ifs.sv
hw/rtl/ppg_slot_ram.sv
hw/rtl/ppg_pool_map.sv
hw/rtl/ppg_seq.sv
hw/rtl/particle_pool_with_gravity_top.sv
hw/rtl/ppg_checker.sv
tb/particle_pool_checker.sv
tb/particle_pool_with_gravity_top_tb.sv
